### sv/adsr_pkg.sv
package adsr_pkg;

  localparam int NumVoices = 16;
  localparam int QDepth    = 4;
  localparam int CfgW      = 16;
  localparam int RegIdxW   = 3;

  // register indexes
  localparam logic [RegIdxW-1:0] REG_PEAK       = 3'd0;
  localparam logic [RegIdxW-1:0] REG_SUSTAIN    = 3'd1;
  localparam logic [RegIdxW-1:0] REG_ATTACK     = 3'd2;
  localparam logic [RegIdxW-1:0] REG_DECAY      = 3'd3;
  localparam logic [RegIdxW-1:0] REG_RELEASE    = 3'd4;
  localparam logic [RegIdxW-1:0] REG_TREM_HALF  = 3'd5;
  localparam logic [RegIdxW-1:0] REG_HI_GAIN    = 3'd6;
  localparam logic [RegIdxW-1:0] REG_LO_GAIN    = 3'd7;

  // register reset values
  localparam logic [15:0] PeakReset     = 16'd255;
  localparam logic [15:0] SustainReset  = 16'd192;
  localparam logic [15:0] AttackReset   = 16'd8;
  localparam logic [15:0] DecayReset    = 16'd2;
  localparam logic [15:0] ReleaseReset  = 16'd4;
  localparam logic [15:0] TremHalfReset = 16'd100;
  localparam logic [9:0]  TremHighReset = 10'd384;
  localparam logic [9:0]  TremLowReset  = 10'd171;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_WHEEL    = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_e;

  typedef struct packed {
    opcode_e    op;
    logic [6:0] note;
    logic [6:0] amount;
  } item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

### sv/adsr_envelope_bank_tremolo_top.sv
// a tick steps the tremolo and forms the gain in S_G1 to S_G3, then walks the voices in turn
// through S_ADV and S_MUL with one result per voice; a stalled output holds the walk in S_MUL
// note on scales its settings in S_SCALE, then scans for a free voice; note off scans for
// its note; wheel is taken in idle; the voice walk is serial, a 4-deep queue decouples the input
// reset: all voices idle, registers at their defaults, tremolo high, wheel at zero
module adsr_envelope_bank_tremolo_top
  import adsr_pkg::*;
#(
  parameter int VOICES = NumVoices
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [6:0]         note_number_i,
  input  logic [6:0]         amount_i,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         voice_index_o,
  output logic [7:0]         amplitude_o,
  output logic               amp_changed_o,
  output logic               voice_freed_o,
  output logic               hit_o,
  output logic               last_of_run_o
);

  logic      push, pop;
  item_t     push_item, head_item;
  q_status_t q_status;

  // request intake
  adsr_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .note_number_i (note_number_i),
    .amount_i      (amount_i),
    .q_status_i    (q_status),
    .push_o        (push),
    .item_o        (push_item)
  );

  // request queue
  adsr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .item_o   (head_item),
    .status_o (q_status)
  );

  // voice engine
  adsr_back #(.VOICES(VOICES)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .q_status_i    (q_status),
    .q_item_i      (head_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .voice_index_o (voice_index_o),
    .amplitude_o   (amplitude_o),
    .amp_changed_o (amp_changed_o),
    .voice_freed_o (voice_freed_o),
    .hit_o         (hit_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

### sv/adsr_front.sv
module adsr_front
  import adsr_pkg::*;
(
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [6:0] note_number_i,
  input  logic [6:0] amount_i,
  input  q_status_t  q_status_i,
  output logic       push_o,
  output item_t      item_o
);

  // take a request whenever the queue has room
  assign in_ready_o = !q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  // decode the opcode and pack the request
  always_comb begin
    item_o.op     = opcode_e'(opcode_i);
    item_o.note   = note_number_i;
    item_o.amount = amount_i;
    // wheel and tick carry no note
    if (item_o.op == OP_TICK || item_o.op == OP_WHEEL) begin
      item_o.note = '0;
    end
  end

endmodule

### sv/adsr_queue.sv
module adsr_queue
  import adsr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  item_t     item_i,
  input  logic      pop_i,
  output item_t     item_o,
  output q_status_t status_o
);

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  item_t          mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign do_pop          = pop_i && (cnt_q != '0);
  assign status_o.valid  = (cnt_q != '0);
  assign status_o.full   = (cnt_q == CntW'(QDepth));
  assign item_o          = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QDepth)) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.full |-> !push_i) else $error("push into full queue");
  a_pop_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !push_i) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("pop did not drain");
`endif

endmodule

### sv/adsr_back.sv
module adsr_back
  import adsr_pkg::*;
#(
  parameter int VOICES = NumVoices
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  q_status_t          q_status_i,
  input  item_t              q_item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         voice_index_o,
  output logic [7:0]         amplitude_o,
  output logic               amp_changed_o,
  output logic               voice_freed_o,
  output logic               hit_o,
  output logic               last_of_run_o
);

  localparam int IdxW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(VOICES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_TREM, S_G1, S_G2, S_G3, S_ADV, S_MUL, S_SCALE, S_SCAN
  } state_e;

  // configuration
  logic [15:0] peak_q, sus_q, att_q, dec_q, rel_q, half_q;
  logic [9:0]  hi_gain_q, lo_gain_q;

  // shared state
  state_e      state_q;
  item_t       cur_q;
  logic [IdxW-1:0] idx_q;
  logic [2:0]  sel_q;
  logic [15:0] trem_cnt_q;
  logic        trem_up_q;
  logic [6:0]  wheel_q;
  logic signed [18:0] prod_q;
  logic [16:0] mag_q;
  logic        neg_q;
  logic [10:0] q0_q;
  logic [10:0] gain_q;
  logic [15:0] amp_r_q;
  logic        freed_q;
  logic [15:0] sc_q [5];

  // per-voice state
  phase_e      phase_q [VOICES];
  logic [15:0] env_q   [VOICES];
  logic        busy_q  [VOICES];
  logic [7:0]  sent_q  [VOICES];
  logic [15:0] vpeak_q [VOICES];
  logic [15:0] vsus_q  [VOICES];
  logic [15:0] vatt_q  [VOICES];
  logic [15:0] vdec_q  [VOICES];
  logic [15:0] vrel_q  [VOICES];
  logic [6:0]  vnote_q [VOICES];

  // output register
  logic        ov_q;
  logic [5:0]  o_idx_q;
  logic [7:0]  o_amp_q;
  logic        o_chg_q, o_freed_q, o_hit_q, o_last_q;

  logic        slot_free;
  assign slot_free = !ov_q || out_ready_i;

  // selected voice
  phase_e      ph_rd;
  logic [15:0] a_rd;
  assign ph_rd = phase_q[idx_q];
  assign a_rd  = env_q[idx_q];

  // envelope advance for the selected voice
  phase_e      ph_nx;
  logic [15:0] a_nx;
  logic        fr_nx;
  logic [16:0] att_sum;
  logic signed [17:0] dec_diff;
  always_comb begin
    ph_nx    = ph_rd;
    a_nx     = a_rd;
    fr_nx    = 1'b0;
    att_sum  = {1'b0, a_rd} + {1'b0, vatt_q[idx_q]};
    dec_diff = $signed({2'b0, a_rd}) - $signed({2'b0, vdec_q[idx_q]});
    unique case (ph_rd)
      PH_ATTACK: begin
        if (att_sum >= {1'b0, vpeak_q[idx_q]}) begin
          ph_nx = PH_DECAY;
          a_nx  = vpeak_q[idx_q];
        end else begin
          a_nx = att_sum[15:0];
        end
      end
      PH_DECAY: begin
        if (dec_diff <= $signed({2'b0, vsus_q[idx_q]})) begin
          ph_nx = PH_SUSTAIN;
          a_nx  = vsus_q[idx_q];
        end else begin
          a_nx = dec_diff[15:0];
        end
      end
      PH_SUSTAIN: a_nx = vsus_q[idx_q];
      PH_RELEASE: begin
        if (a_rd <= vrel_q[idx_q]) begin
          ph_nx = PH_IDLE;
          a_nx  = '0;
          fr_nx = 1'b1;
        end else begin
          a_nx = a_rd - vrel_q[idx_q];
        end
      end
      default: begin
        ph_nx = PH_IDLE;
        a_nx  = '0;
      end
    endcase
  end

  // tremolo gain datapath
  logic [15:0] cnt_inc;
  logic [9:0]  target;
  logic signed [10:0] tdiff;
  logic signed [7:0]  wh;
  logic [16:0] mag_nx;
  logic [24:0] recip;
  logic [17:0] qm, rem;
  logic [10:0] qfix;
  assign cnt_inc = trem_cnt_q + 16'd1;
  assign target  = trem_up_q ? hi_gain_q : lo_gain_q;
  assign tdiff   = $signed({1'b0, target}) - 11'sd256;
  assign wh      = $signed({1'b0, wheel_q});
  assign mag_nx  = prod_q[18] ? 17'(-prod_q) : prod_q[16:0];
  assign recip   = 25'(mag_nx) * 25'd129;
  assign qm      = 18'(q0_q) * 18'd127;
  assign rem     = {1'b0, mag_q} - qm;
  assign qfix    = q0_q + 11'(rem >= 18'd127);

  // amplitude scale and clamp
  logic [26:0] mprod;
  logic [7:0]  amp_cl;
  assign mprod  = 27'(amp_r_q) * 27'(gain_q);
  assign amp_cl = (mprod[26:8] > 19'd255) ? 8'd255 : mprod[15:8];

  // velocity scale, one register per cycle
  logic [15:0] sel_cfg;
  logic [22:0] vprod;
  always_comb begin
    case (sel_q)
      3'd0:    sel_cfg = peak_q;
      3'd1:    sel_cfg = sus_q;
      3'd2:    sel_cfg = att_q;
      3'd3:    sel_cfg = dec_q;
      default: sel_cfg = rel_q;
    endcase
  end
  assign vprod = 23'(cur_q.amount) * 23'(sel_cfg);

  // voice search match
  logic on_hit, off_hit, scan_hit;
  assign on_hit   = !busy_q[idx_q];
  assign off_hit  = busy_q[idx_q] && (vnote_q[idx_q] == cur_q.note) &&
                    (ph_rd != PH_RELEASE);
  assign scan_hit = (cur_q.op == OP_NOTE_ON) ? on_hit : off_hit;

  // output register loads this cycle
  logic out_load;
  assign out_load = slot_free && ((state_q == S_MUL) ||
                    (state_q == S_SCAN && (scan_hit || idx_q == LastIdx)));

  assign pop_o = (state_q == S_IDLE) && q_status_i.valid;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q    <= PeakReset;
      sus_q     <= SustainReset;
      att_q     <= AttackReset;
      dec_q     <= DecayReset;
      rel_q     <= ReleaseReset;
      half_q    <= TremHalfReset;
      hi_gain_q <= TremHighReset;
      lo_gain_q <= TremLowReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PEAK:      peak_q    <= cfg_data_i;
        REG_SUSTAIN:   sus_q     <= cfg_data_i;
        REG_ATTACK:    att_q     <= cfg_data_i;
        REG_DECAY:     dec_q     <= cfg_data_i;
        REG_RELEASE:   rel_q     <= cfg_data_i;
        REG_TREM_HALF: half_q    <= cfg_data_i;
        REG_HI_GAIN:   hi_gain_q <= cfg_data_i[9:0];
        REG_LO_GAIN:   lo_gain_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // sequencer, voice control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      sel_q       <= '0;
      trem_cnt_q  <= '0;
      trem_up_q   <= 1'b1;
      wheel_q     <= '0;
      ov_q        <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        phase_q[i] <= PH_IDLE;
        env_q[i]   <= '0;
        busy_q[i]  <= 1'b0;
        sent_q[i]  <= '0;
      end
    end else begin
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_status_i.valid) begin
            idx_q <= '0;
            sel_q <= '0;
            unique case (q_item_i.op)
              OP_TICK:     state_q <= S_TREM;
              OP_NOTE_ON:  state_q <= S_SCALE;
              OP_NOTE_OFF: state_q <= S_SCAN;
              default:     wheel_q <= q_item_i.amount;
            endcase
          end
        end
        S_TREM: begin
          if (cnt_inc >= half_q) begin
            trem_cnt_q <= '0;
            trem_up_q  <= !trem_up_q;
          end else begin
            trem_cnt_q <= cnt_inc;
          end
          state_q <= S_G1;
        end
        S_G1: state_q <= S_G2;
        S_G2: state_q <= S_G3;
        S_G3: state_q <= S_ADV;
        S_ADV: begin
          phase_q[idx_q] <= ph_nx;
          env_q[idx_q]   <= a_nx;
          if (fr_nx) begin
            busy_q[idx_q] <= 1'b0;
          end
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (slot_free) begin
            o_idx_q        <= 6'(idx_q);
            o_amp_q        <= amp_cl;
            o_chg_q        <= (amp_cl != sent_q[idx_q]);
            o_freed_q      <= freed_q;
            o_hit_q        <= 1'b0;
            o_last_q       <= (idx_q == LastIdx);
            sent_q[idx_q]  <= amp_cl;
            if (idx_q == LastIdx) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_ADV;
            end
          end
        end
        S_SCALE: begin
          sel_q <= sel_q + 3'd1;
          if (sel_q == 3'd4) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (slot_free) begin
            if (scan_hit) begin
              if (cur_q.op == OP_NOTE_ON) begin
                busy_q[idx_q]  <= 1'b1;
                phase_q[idx_q] <= PH_ATTACK;
              end else begin
                phase_q[idx_q] <= PH_RELEASE;
              end
              o_idx_q   <= 6'(idx_q);
              o_hit_q   <= 1'b1;
              o_amp_q   <= '0;
              o_chg_q   <= 1'b0;
              o_freed_q <= 1'b0;
              o_last_q  <= 1'b1;
              state_q   <= S_IDLE;
            end else if (idx_q == LastIdx) begin
              o_idx_q   <= '0;
              o_hit_q   <= 1'b0;
              o_amp_q   <= '0;
              o_chg_q   <= 1'b0;
              o_freed_q <= 1'b0;
              o_last_q  <= 1'b1;
              state_q   <= S_IDLE;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_item_i;
    end
    prod_q <= 19'(tdiff * wh);
    if (state_q == S_G2) begin
      mag_q <= mag_nx;
      neg_q <= prod_q[18];
      q0_q  <= recip[24:14];
    end
    if (state_q == S_G3) begin
      gain_q <= neg_q ? (11'd256 - qfix) : (11'd256 + qfix);
    end
    if (state_q == S_ADV) begin
      amp_r_q <= a_nx;
      freed_q <= fr_nx;
    end
    if (state_q == S_SCALE) begin
      sc_q[sel_q] <= vprod[22:7];
    end
  end

  // per-voice settings written on note on
  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && slot_free && cur_q.op == OP_NOTE_ON && on_hit) begin
      vnote_q[idx_q] <= cur_q.note;
      vpeak_q[idx_q] <= sc_q[0];
      vsus_q[idx_q]  <= sc_q[1];
      vatt_q[idx_q]  <= (sc_q[2] == '0) ? 16'd1 : sc_q[2];
      vdec_q[idx_q]  <= (sc_q[3] == '0) ? 16'd1 : sc_q[3];
      vrel_q[idx_q]  <= (sc_q[4] == '0) ? 16'd1 : sc_q[4];
    end
  end

  assign out_valid_o   = ov_q;
  assign voice_index_o = o_idx_q;
  assign amplitude_o   = o_amp_q;
  assign amp_changed_o = o_chg_q;
  assign voice_freed_o = o_freed_q;
  assign hit_o         = o_hit_q;
  assign last_of_run_o = o_last_q;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastIdx) else $error("voice index out of range");
  a_busy_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q[idx_q] == (phase_q[idx_q] != PH_IDLE))
    else $error("busy flag and phase disagree");
  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> (amplitude_o == '0 && !amp_changed_o &&
                                !voice_freed_o && last_of_run_o))
    else $error("note result carries tick fields");
`endif

endmodule

### test/adsr_envelope_bank_tremolo_top_tb.sv
module adsr_envelope_bank_tremolo_top_tb;
  import adsr_pkg::*;

  localparam int VOICES     = NumVoices;
  localparam int DrainWait  = 2 * VOICES + 40;
  localparam int CycleLimit = 600000;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic [5:0] voice;
    logic [7:0] amp;
    logic       changed;
    logic       freed;
    logic       hit;
    logic       last;
  } result_t;

  typedef struct {
    opcode_e    op;
    logic [6:0] note;
    logic [6:0] amount;
    bit         typed;
    logic [5:0] voice;
    logic       hit;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] opcode_i = OP_TICK;
  logic [6:0] note_number_i = '0;
  logic [6:0] amount_i = '0;
  logic cfg_we_i = 1'b0;
  logic [RegIdxW-1:0] cfg_idx_i = REG_PEAK;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [5:0] voice_index_o;
  logic [7:0] amplitude_o;
  logic amp_changed_o, voice_freed_o, hit_o, last_of_run_o;

  adsr_envelope_bank_tremolo_top u_top (.*);

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow configuration
  int peak_cfg, sustain_cfg, attack_cfg, decay_cfg, release_cfg;
  int half_cfg, high_gain_cfg, low_gain_cfg;

  // shadow voice state
  phase_e env_phase [VOICES];
  int env_amp [VOICES];
  int v_peak [VOICES], v_sustain [VOICES];
  int v_attack [VOICES], v_decay [VOICES], v_release [VOICES];
  int v_note [VOICES];
  bit v_busy [VOICES];
  int sent_amp [VOICES];
  int trem_count;
  bit trem_up;
  int wheel;

  result_t expected_results [$];
  int errors = 0;
  int cycles = 0;

  // typed expectation for the request on the bus
  bit cur_typed = 1'b0;
  logic [5:0] cur_voice = '0;
  logic cur_hit = 1'b0;

  bit long_hold = 1'b0;
  int burst_left = 0;

  function automatic int vel_scale(int v, int c);
    return (v * c) >> 7;
  endfunction

  function automatic int min_one(int x);
    return (x == 0) ? 1 : x;
  endfunction

  // one envelope step, returns 1 when release completes
  function automatic bit step_voice(int i);
    int a;
    a = env_amp[i];
    case (env_phase[i])
      PH_ATTACK: begin
        if (a + v_attack[i] >= v_peak[i]) begin
          env_phase[i] = PH_DECAY;
          env_amp[i] = v_peak[i];
        end else env_amp[i] = a + v_attack[i];
      end
      PH_DECAY: begin
        if (a - v_decay[i] <= v_sustain[i]) begin
          env_phase[i] = PH_SUSTAIN;
          env_amp[i] = v_sustain[i];
        end else env_amp[i] = a - v_decay[i];
      end
      PH_SUSTAIN: env_amp[i] = v_sustain[i];
      PH_RELEASE: begin
        if (a <= v_release[i]) begin
          env_phase[i] = PH_IDLE;
          env_amp[i] = 0;
          v_busy[i] = 1'b0;
          v_note[i] = 0;
          return 1'b1;
        end
        env_amp[i] = a - v_release[i];
      end
      default: begin
        env_phase[i] = PH_IDLE;
        env_amp[i] = 0;
      end
    endcase
    return 1'b0;
  endfunction

  // predict the results of one accepted request
  function automatic void predict_request(opcode_e op, int note, int amt);
    int target, gain, m, amp;
    result_t r;
    bit done;
    r = '0;
    r.last = 1'b1;
    done = 1'b0;
    case (op)
      OP_TICK: begin
        trem_count = (trem_count + 1) & 16'hFFFF;
        if (trem_count >= half_cfg) begin
          trem_count = 0;
          trem_up = !trem_up;
        end
        target = trem_up ? high_gain_cfg : low_gain_cfg;
        gain = 256 + ((target - 256) * wheel) / 127;
        for (int i = 0; i < VOICES; i++) begin
          r.freed = step_voice(i);
          m = (env_amp[i] * gain) >> 8;
          amp = (m > 255) ? 255 : m;
          r.voice = 6'(i);
          r.amp = 8'(amp);
          r.changed = (amp != sent_amp[i]);
          r.hit = 1'b0;
          r.last = (i == VOICES - 1);
          sent_amp[i] = amp;
          expected_results.push_back(r);
        end
      end
      OP_NOTE_ON: begin
        for (int i = 0; i < VOICES && !done; i++) begin
          if (!v_busy[i]) begin
            v_busy[i] = 1'b1;
            v_note[i] = note;
            env_phase[i] = PH_ATTACK;
            v_peak[i] = vel_scale(amt, peak_cfg);
            v_sustain[i] = vel_scale(amt, sustain_cfg);
            v_attack[i] = min_one(vel_scale(amt, attack_cfg));
            v_decay[i] = min_one(vel_scale(amt, decay_cfg));
            v_release[i] = min_one(vel_scale(amt, release_cfg));
            r.voice = 6'(i);
            r.hit = 1'b1;
            done = 1'b1;
          end
        end
        expected_results.push_back(r);
      end
      OP_NOTE_OFF: begin
        for (int i = 0; i < VOICES && !done; i++) begin
          if (v_busy[i] && v_note[i] == note && env_phase[i] != PH_RELEASE) begin
            env_phase[i] = PH_RELEASE;
            r.voice = 6'(i);
            r.hit = 1'b1;
            done = 1'b1;
          end
        end
        expected_results.push_back(r);
      end
      default: wheel = amt;
    endcase
  endfunction

  // request monitor
  always @(posedge clk_i) begin
    result_t r;
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_request(opcode_e'(opcode_i), note_number_i, amount_i);
      if (cur_typed) begin
        r = expected_results.pop_back();
        r.voice = cur_voice;
        r.hit = cur_hit;
        expected_results.push_back(r);
      end
    end
  end

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual voice %0d amp %0d",
                 $time, voice_index_o, amplitude_o);
        errors++;
      end else begin
        e = expected_results.pop_front();
        check_field("voice_index", e.voice, voice_index_o);
        check_field("amplitude", e.amp, amplitude_o);
        check_field("amp_changed", e.changed, amp_changed_o);
        check_field("voice_freed", e.freed, voice_freed_o);
        check_field("hit", e.hit, hit_o);
        check_field("last_of_run", e.last, last_of_run_o);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("adsr_envelope_bank_tremolo_top_tb failed");
      $finish;
    end
  end

  // receiver: changing stall patterns, plus one long hold-off on request
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        long_hold = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
      end
      left--;
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // offer one request, in bursts with random gaps
  task automatic send_request(opcode_e op, logic [6:0] note, logic [6:0] amt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 14);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    opcode_i <= op;
    note_number_i <= note;
    amount_i <= amt;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [RegIdxW-1:0] idx, int data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CfgW'(data);
    @(posedge clk_i);
    case (idx)
      REG_PEAK:      peak_cfg = data & 16'hFFFF;
      REG_SUSTAIN:   sustain_cfg = data & 16'hFFFF;
      REG_ATTACK:    attack_cfg = data & 16'hFFFF;
      REG_DECAY:     decay_cfg = data & 16'hFFFF;
      REG_RELEASE:   release_cfg = data & 16'hFFFF;
      REG_TREM_HALF: half_cfg = data & 16'hFFFF;
      REG_HI_GAIN:   high_gain_cfg = data & 10'h3FF;
      default:       low_gain_cfg = data & 10'h3FF;
    endcase
  endtask

  task automatic cfg_all(int pk, int su, int at, int de, int re, int hp, int hg, int lg);
    cfg_write(REG_PEAK, pk);
    cfg_write(REG_SUSTAIN, su);
    cfg_write(REG_ATTACK, at);
    cfg_write(REG_DECAY, de);
    cfg_write(REG_RELEASE, re);
    cfg_write(REG_TREM_HALF, hp);
    cfg_write(REG_HI_GAIN, hg);
    cfg_write(REG_LO_GAIN, lg);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_requests(int count);
    int sel;
    opcode_e op;
    logic [6:0] note, amt;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 99);
      op = (sel < 30) ? OP_TICK : (sel < 62) ? OP_NOTE_ON :
           (sel < 88) ? OP_NOTE_OFF : OP_WHEEL;
      note = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127)) :
                                           7'($urandom_range(60, 63));
      amt = 7'($urandom_range(0, 127));
      if (k == count / 3) long_hold = 1'b1;
      send_request(op, note, amt);
    end
  endtask

  dir_row_t dir_rows [19];

  initial begin
    // reset values of the shadow state
    peak_cfg = PeakReset;
    sustain_cfg = SustainReset;
    attack_cfg = AttackReset;
    decay_cfg = DecayReset;
    release_cfg = ReleaseReset;
    half_cfg = TremHalfReset;
    high_gain_cfg = TremHighReset;
    low_gain_cfg = TremLowReset;
    for (int i = 0; i < VOICES; i++) begin
      env_phase[i] = PH_IDLE;
      env_amp[i] = 0;
      v_peak[i] = 0;
      v_sustain[i] = 0;
      v_attack[i] = 0;
      v_decay[i] = 0;
      v_release[i] = 0;
      v_note[i] = 0;
      v_busy[i] = 1'b0;
      sent_amp[i] = 0;
    end
    trem_count = 0;
    trem_up = 1'b1;
    wheel = 0;

    dir_rows = '{
      '{OP_NOTE_OFF, 7'd5,   7'd0,   1'b1, 6'd0, 1'b0},  // no voice busy yet
      '{OP_TICK,     7'd0,   7'd0,   1'b0, 6'd0, 1'b0},
      '{OP_WHEEL,    7'd0,   7'd127, 1'b0, 6'd0, 1'b0},
      '{OP_NOTE_ON,  7'd127, 7'd127, 1'b1, 6'd0, 1'b1},
      '{OP_NOTE_ON,  7'd0,   7'd0,   1'b1, 6'd1, 1'b1},  // velocity zero
      '{OP_NOTE_ON,  7'd64,  7'd1,   1'b1, 6'd2, 1'b1},
      '{OP_TICK,     7'd0,   7'd0,   1'b0, 6'd0, 1'b0},
      '{OP_TICK,     7'd0,   7'd0,   1'b0, 6'd0, 1'b0},
      '{OP_TICK,     7'd0,   7'd0,   1'b0, 6'd0, 1'b0},
      '{OP_NOTE_OFF, 7'd127, 7'd0,   1'b1, 6'd0, 1'b1},
      '{OP_NOTE_OFF, 7'd127, 7'd0,   1'b1, 6'd0, 1'b0},  // already releasing
      '{OP_NOTE_OFF, 7'd0,   7'd0,   1'b1, 6'd1, 1'b1},
      '{OP_WHEEL,    7'd0,   7'd64,  1'b0, 6'd0, 1'b0},
      '{OP_TICK,     7'd0,   7'd0,   1'b0, 6'd0, 1'b0},
      '{OP_TICK,     7'd0,   7'd0,   1'b0, 6'd0, 1'b0},
      '{OP_WHEEL,    7'd0,   7'd0,   1'b0, 6'd0, 1'b0},
      '{OP_TICK,     7'd0,   7'd0,   1'b0, 6'd0, 1'b0},
      '{OP_NOTE_ON,  7'd85,  7'd42,  1'b0, 6'd0, 1'b0},
      '{OP_TICK,     7'd0,   7'd0,   1'b0, 6'd0, 1'b0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset settings
    foreach (dir_rows[r]) begin
      cur_typed <= dir_rows[r].typed;
      cur_voice <= dir_rows[r].voice;
      cur_hit <= dir_rows[r].hit;
      send_request(dir_rows[r].op, dir_rows[r].note, dir_rows[r].amount);
    end
    cur_typed <= 1'b0;
    random_requests(80);
    wait_idle();

    // top extremes, toggle on every tick
    cfg_all(65535, 65535, 65535, 0, 65535, 0, 1023, 0);
    random_requests(90);
    wait_idle();

    // random settings with short tremolo
    cfg_all($urandom_range(0, 2000), $urandom_range(0, 2000), $urandom_range(0, 300),
            $urandom_range(0, 300), $urandom_range(0, 300), $urandom_range(1, 8),
            $urandom_range(0, 1023), $urandom_range(0, 1023));
    random_requests(90);
    wait_idle();

    // bottom extremes, longest tremolo
    cfg_all(0, 0, 0, 65535, 0, 65535, 0, 1023);
    random_requests(90);
    wait_idle();

    if (errors == 0) begin
      $display("adsr_envelope_bank_tremolo_top_tb passed");
    end else begin
      $display("adsr_envelope_bank_tremolo_top_tb failed");
    end
    $finish;
  end

endmodule
